### rtl/llt_pkg.sv
// ----------------------------------------------------------------------------
// Lease lock table package
// Shared word types, operation and status codes, and default sizes.
// ----------------------------------------------------------------------------
package llt_pkg;

  localparam int DEFAULT_ENTRIES = 16;
  localparam logic [31:0] LEASE_DEFAULT = 32'd300;  // five minutes

  // Widest slot index the table supports (256 entries).
  localparam int IDX_W_MAX = 8;

  // Function field codes of a request word.
  localparam logic [1:0] FUNC_ACQUIRE = 2'd0;
  localparam logic [1:0] FUNC_RENEW   = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  // Classified operations as they travel through the command queue.
  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RENEW   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_INVALID = 2'd3;

  // Response status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_LOCKED    = 3'd1;
  localparam logic [2:0] ST_BROKEN    = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BADHANDLE = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  fsys_id;
    logic [63:0] file_path;
    logic [3:0]  handle;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] granted_handle;
  } rsp_t;

  // Classified command held in the queue between front and back.
  typedef struct packed {
    logic [1:0]  op;
    logic        handle_ok;
    logic [7:0]  fsys_id;
    logic [63:0] file_path;
    logic [3:0]  handle;
    logic [31:0] now;
  } cmd_t;

  // One table entry as stored in the slot memory.
  typedef struct packed {
    logic        live;
    logic [7:0]  fsys;
    logic [63:0] path;
    logic [31:0] expiry;
  } entry_t;

endpackage

### rtl/llt_ram.sv
// ----------------------------------------------------------------------------
// Lease lock table RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module llt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/llt_front.sv
// ----------------------------------------------------------------------------
// Lease lock table front end
// Accepts request words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module llt_front #(
  parameter int ENTRIES = llt_pkg::DEFAULT_ENTRIES
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  llt_pkg::req_t req,
  input  logic          pop,
  output logic          q_empty,
  output llt_pkg::cmd_t q_head
);
  import llt_pkg::*;

  localparam logic [1:0] QDEPTH = 2'd2;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       cmd_in;

  assign req_stall = (count == QDEPTH);
  assign push      = req_valid && !req_stall;
  assign q_empty   = (count == 2'd0);
  assign q_head    = slots[rd_ptr];

  always_comb begin
    cmd_in.fsys_id   = req.fsys_id;
    cmd_in.file_path = req.file_path;
    cmd_in.handle    = req.handle;
    cmd_in.now       = req.now;
    cmd_in.handle_ok = (int'(req.handle) < ENTRIES);
    unique case (req.func)
      FUNC_ACQUIRE: cmd_in.op = OP_ACQUIRE;
      FUNC_RENEW:   cmd_in.op = OP_RENEW;
      FUNC_RELEASE: cmd_in.op = OP_RELEASE;
      default:      cmd_in.op = OP_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### rtl/llt_back.sv
// ----------------------------------------------------------------------------
// Lease lock table back end
// Executes queued commands against the slot table and drives the response.
// ----------------------------------------------------------------------------
module llt_back #(
  parameter int ENTRIES = llt_pkg::DEFAULT_ENTRIES
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   lifetime,
  input  logic          q_empty,
  input  llt_pkg::cmd_t q_head,
  output logic          pop,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output llt_pkg::rsp_t rsp
);
  import llt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ENTRIES);
  localparam int ENTRY_W = $bits(entry_t);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_RENEW = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]       state;
  cmd_t             cmd;
  rsp_t             res;
  logic [CNT_W-1:0] cnt;
  logic             eval_valid;
  logic [IDX_W-1:0] eval_idx;
  logic             refused;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             used [ENTRIES];

  logic [IDX_W_MAX:0] head_ext;
  logic [IDX_W_MAX:0] cmd_ext;
  logic [IDX_W_MAX:0] free_ext;
  logic [IDX_W-1:0]   head_idx;
  logic [IDX_W-1:0]   cmd_idx;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd;

  logic        key_hit;
  logic        mark_dead;
  logic        alloc;
  logic        broken;
  logic        renew_ok;
  logic [31:0] new_expiry;
  logic        out_free;

  assign head_ext = {{(IDX_W_MAX - 3){1'b0}}, q_head.handle};
  assign cmd_ext  = {{(IDX_W_MAX - 3){1'b0}}, cmd.handle};
  assign free_ext = (IDX_W_MAX + 1)'(free_idx);
  assign head_idx = head_ext[IDX_W-1:0];
  assign cmd_idx  = cmd_ext[IDX_W-1:0];

  assign rd         = entry_t'(ram_rdata);
  assign new_expiry = cmd.now + lifetime;
  assign out_free   = !rsp_valid || !rsp_stall;
  assign pop        = (state == S_IDLE) && !q_empty;

  // Only used entries are ever compared, so live and key bits are defined.
  assign key_hit   = used[eval_idx] && rd.live && (rd.fsys == cmd.fsys_id) &&
                     (rd.path == cmd.file_path);
  assign mark_dead = (state == S_SCAN) && eval_valid && key_hit && (rd.expiry < cmd.now);
  assign alloc     = (state == S_SCAN) && !eval_valid && !refused && free_found;
  assign broken    = !rd.live || (rd.expiry < cmd.now) || (rd.fsys != cmd.fsys_id);
  assign renew_ok  = (state == S_RENEW) && !broken;

  always_comb begin
    ram_raddr = '0;
    if (state == S_SCAN) begin
      ram_raddr = cnt[IDX_W-1:0];
    end else if (q_head.op != OP_ACQUIRE) begin
      ram_raddr = head_idx;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = eval_idx;
    ram_wdata = rd;
    if (mark_dead) begin
      ram_we         = 1'b1;
      ram_wdata.live = 1'b0;
    end else if (alloc) begin
      ram_we    = 1'b1;
      ram_waddr = free_idx;
      ram_wdata = '{live: 1'b1, fsys: cmd.fsys_id, path: cmd.file_path, expiry: new_expiry};
    end else if (renew_ok) begin
      ram_we    = 1'b1;
      ram_waddr = cmd_idx;
      ram_wdata = '{live: 1'b1, fsys: rd.fsys, path: rd.path, expiry: new_expiry};
    end
  end

  llt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      eval_valid <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        used[i] <= 1'b0;
      end
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_FIN)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cmd                <= q_head;
            res.granted_handle <= 4'd0;
            unique case (q_head.op)
              OP_ACQUIRE: begin
                res.status <= ST_OK;
                cnt        <= CNT_W'(1);
                eval_valid <= 1'b1;
                eval_idx   <= '0;
                refused    <= 1'b0;
                free_found <= 1'b0;
                state      <= S_SCAN;
              end
              OP_RENEW: begin
                if (!q_head.handle_ok || !used[head_idx]) begin
                  res.status <= ST_BADHANDLE;
                  state      <= S_FIN;
                end else begin
                  res.status <= ST_OK;
                  state      <= S_RENEW;
                end
              end
              OP_RELEASE: begin
                if (!q_head.handle_ok || !used[head_idx]) begin
                  res.status <= ST_BADHANDLE;
                end else begin
                  res.status     <= ST_OK;
                  used[head_idx] <= 1'b0;
                end
                state <= S_FIN;
              end
              default: begin
                res.status <= ST_BADHANDLE;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (eval_valid) begin
            if (!used[eval_idx]) begin
              if (!free_found) begin
                free_found <= 1'b1;
                free_idx   <= eval_idx;
              end
            end else if (key_hit && (rd.expiry >= cmd.now)) begin
              refused <= 1'b1;
            end
          end
          if (cnt != CNT_END) begin
            eval_idx   <= cnt[IDX_W-1:0];
            cnt        <= cnt + CNT_W'(1);
            eval_valid <= 1'b1;
          end else begin
            eval_valid <= 1'b0;
          end
          if (!eval_valid) begin
            if (refused) begin
              res.status <= ST_LOCKED;
            end else if (!free_found) begin
              res.status <= ST_FULL;
            end else begin
              used[free_idx]     <= 1'b1;
              res.granted_handle <= free_ext[3:0];
            end
            state <= S_FIN;
          end
        end
        S_RENEW: begin
          if (broken) begin
            res.status <= ST_BROKEN;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            rsp       <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/lease_lock_table_top.sv
// ----------------------------------------------------------------------------
// Lease lock table
// Exclusive-access lease table keyed by filesystem id and file path.
// ----------------------------------------------------------------------------
// The block keeps up to ENTRIES leases, each keyed by (fsys_id, file_path)
// with an expiry time. An acquire word walks the whole table: a live entry
// with the same key whose expiry is at or after now refuses the request
// (locked), while matching entries that have already expired are marked
// dead so that a later renew through their handle reports a broken lease.
// If nothing refuses, the lowest free slot takes the key with expiry
// now + lifetime and its index comes back as granted_handle; with no free
// slot the answer is table full. Renew extends a live, unexpired lease of
// the same filesystem, and release frees a slot; an unused or out-of-range
// handle, or an unknown function code, answers bad handle. All time
// arithmetic wraps modulo 2^32. Request words enter a two-word queue, so up
// to two words are taken while the table is busy or a response waits. The
// table walk reads one slot per cycle from the slot memory; a renew passes a
// renew state, and a release or a bad request goes straight to the response
// state. The lifetime register resets to 300; the user must write it with
// cfg_we only while the block is idle, which the block itself does not enforce.
// Slot contents are never cleared by reset: only the used bits reset.
module lease_lock_table_top #(
  parameter int ENTRIES = llt_pkg::DEFAULT_ENTRIES
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  llt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output llt_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata
);
  import llt_pkg::*;

  logic [31:0] lifetime;
  logic        q_empty;
  logic        pop;
  cmd_t        q_head;

  // Lease lifetime register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime <= LEASE_DEFAULT;
    end else if (cfg_we) begin
      lifetime <= cfg_wdata;
    end
  end

  // The front end classifies each word and holds it until the back end is free.
  llt_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .pop       (pop),
    .q_empty   (q_empty),
    .q_head    (q_head)
  );

  // The back end walks the table and owns the response register.
  llt_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .lifetime  (lifetime),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // The back end never takes a word from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> !q_empty)
    else $error("command popped from empty queue");

  // A handle is only granted together with an ok status.
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != ST_OK)) |-> (rsp.granted_handle == 4'd0))
    else $error("handle granted on a failed request");

  // No response is pending right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

### bench/tb_lease_lock_table_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lease lock table testbench
// Drives acquire, renew, release and undefined-function words into the lease
// table under random sender gaps and receiver stalls. It predicts every
// response from its own copy of the table and the lifetime register and
// checks the responses in order.
// ----------------------------------------------------------------------------
module tb_lease_lock_table_top;
  import llt_pkg::*;

  localparam int SLOTS = 16;
  // The function field has one code that the block does not define.
  localparam logic [1:0] FUNC_UNDEFINED = 2'd3;
  // An acquire walks the whole table; this pause lets that walk finish with
  // margin before a lifetime write and at the end of the run.
  localparam int SETTLE = 40;
  // Cycles without any accepted word before the run is declared hung.
  localparam int HANG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 6;
  localparam int WORDS_PER_PHASE = 90;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  lease_lock_table_top #(.ENTRIES(SLOTS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow copy of the lease table. Only the used bits matter after reset;
  // the other fields are only looked at for used slots.
  // --------------------------------------------------------------------------
  logic        lease_used   [SLOTS];
  logic        lease_live   [SLOTS];
  logic [7:0]  lease_fs     [SLOTS];
  logic [63:0] lease_path   [SLOTS];
  logic [31:0] lease_expiry [SLOTS];
  logic [31:0] lease_len = LEASE_DEFAULT;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      lease_used[i]   = 1'b0;
      lease_live[i]   = 1'b0;
      lease_fs[i]     = '0;
      lease_path[i]   = '0;
      lease_expiry[i] = '0;
    end
  end

  // Words waiting to be driven, and responses owed by the block, in order.
  req_t pending_words[$];
  rsp_t answers_due[$];
  int   errors = 0;

  // Applies one accepted request word to the shadow table and returns the
  // response the block owes for it.
  function automatic rsp_t lease_outcome(req_t w);
    rsp_t a;
    int   free_slot;
    logic refused;
    a.status = ST_OK;
    a.granted_handle = '0;
    case (w.func)
      FUNC_ACQUIRE: begin
        free_slot = -1;
        refused = 1'b0;
        // Every used, live slot holding the key is visited: an unexpired one
        // refuses, an expired one is marked dead on the way.
        for (int i = 0; i < SLOTS; i++) begin
          if (!lease_used[i]) begin
            if (free_slot < 0) free_slot = i;
          end else if (lease_live[i] && lease_fs[i] == w.fsys_id &&
                       lease_path[i] == w.file_path) begin
            if (lease_expiry[i] >= w.now) refused = 1'b1;
            else lease_live[i] = 1'b0;
          end
        end
        if (refused) begin
          a.status = ST_LOCKED;
        end else if (free_slot < 0) begin
          a.status = ST_FULL;
        end else begin
          lease_used[free_slot]   = 1'b1;
          lease_live[free_slot]   = 1'b1;
          lease_fs[free_slot]     = w.fsys_id;
          lease_path[free_slot]   = w.file_path;
          lease_expiry[free_slot] = w.now + lease_len;
          a.granted_handle = 4'(free_slot);
        end
      end
      FUNC_RENEW: begin
        if (!lease_used[w.handle]) begin
          a.status = ST_BADHANDLE;
        end else if (!lease_live[w.handle] || lease_expiry[w.handle] < w.now ||
                     lease_fs[w.handle] != w.fsys_id) begin
          a.status = ST_BROKEN;
        end else begin
          lease_expiry[w.handle] = w.now + lease_len;
        end
      end
      FUNC_RELEASE: begin
        if (!lease_used[w.handle]) begin
          a.status = ST_BADHANDLE;
        end else begin
          lease_used[w.handle] = 1'b0;
          lease_live[w.handle] = 1'b0;
        end
      end
      default: a.status = ST_BADHANDLE;
    endcase
    return a;
  endfunction

  // Only the first ten failures are printed; the rest are counted.
  task automatic log_mismatch(input string what);
    errors++;
    if (errors <= 10) $display("%s", what);
  endtask

  // --------------------------------------------------------------------------
  // Sender: words go out in bursts of random length separated by random gaps.
  // A stalled word is held unchanged. The shadow table is advanced at the
  // edge where the block takes the word.
  // --------------------------------------------------------------------------
  int burst_left = 4;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) answers_due.push_back(lease_outcome(req));
      if (!req_valid || !req_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          req <= pending_words.pop_front();
          req_valid <= 1'b1;
          if (burst_left <= 1) begin
            // One burst in four is long, and independently one gap in four is zero.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: the stall follows a rotating 16-bit pattern that is replaced
  // whenever stall_age runs out. Bit 15 is always cleared, so within one
  // pattern no stall lasts a full rotation. Some patterns are empty, giving
  // stretches with no stall.
  // --------------------------------------------------------------------------
  logic [15:0] stall_pat = '0;
  int          stall_age = 0;
  rsp_t        due;

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (answers_due.size() == 0) begin
          log_mismatch($sformatf("unexpected response: status %0d handle %0d",
                                 rsp.status, rsp.granted_handle));
        end else begin
          due = answers_due.pop_front();
          if (rsp.status !== due.status)
            log_mismatch($sformatf("status mismatch: expected %0d, got %0d",
                                   due.status, rsp.status));
          if (rsp.granted_handle !== due.granted_handle)
            log_mismatch($sformatf("granted_handle mismatch: expected %0d, got %0d",
                                   due.granted_handle, rsp.granted_handle));
        end
      end
      stall_age++;
      if (stall_age == 48) begin
        stall_age = 0;
        case ($urandom_range(0, 3))
          0: stall_pat = '0;
          1: stall_pat = 16'($urandom & $urandom);
          2: stall_pat = 16'($urandom | $urandom);
          default: stall_pat = 16'($urandom);
        endcase
        stall_pat[15] = 1'b0;
      end
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      rsp_stall <= stall_pat[0];
    end
  end

  // --------------------------------------------------------------------------
  // Hang detection: the run ends if no word moves on either side for too long.
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  // Key pool: four filesystem ids crossed with five paths give twenty keys,
  // more than the table holds, so the table fills up and keys collide.
  logic [7:0]  key_fs   [4];
  logic [63:0] key_path [5];
  logic [31:0] gen_now = '0;

  function automatic req_t make_word(logic [1:0] func, logic [7:0] fs,
                                     logic [63:0] path, logic [3:0] h,
                                     logic [31:0] t);
    req_t w;
    w.func = func;
    w.fsys_id = fs;
    w.file_path = path;
    w.handle = h;
    w.now = t;
    return w;
  endfunction

  // Mostly a handle that the shadow table shows in use, else any handle.
  // The shadow lags the generated words by a few, which adds some noise.
  function automatic logic [3:0] held_slot();
    int start;
    start = $urandom_range(0, SLOTS - 1);
    if ($urandom_range(0, 4) != 0) begin
      for (int k = 0; k < SLOTS; k++)
        if (lease_used[(start + k) % SLOTS]) return 4'((start + k) % SLOTS);
    end
    return 4'(start);
  endfunction

  // Builds one random word. Time mostly creeps forward, often stands still
  // so that expiry ties occur, and now and then jumps anywhere.
  function automatic req_t next_word(int step_max);
    req_t w;
    int   pick;
    int   key;
    w.func = FUNC_ACQUIRE;
    w.fsys_id = 8'($urandom);
    w.file_path = {$urandom, $urandom};
    w.handle = 4'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) gen_now = $urandom;
    else if (pick >= 35) gen_now += $urandom_range(1, step_max);
    w.now = gen_now;
    key = $urandom_range(0, 19);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      w.fsys_id = key_fs[key % 4];
      w.file_path = key_path[key % 5];
    end else if (pick < 65) begin
      w.func = FUNC_RENEW;
      w.handle = held_slot();
      if ($urandom_range(0, 6) != 0) w.fsys_id = lease_fs[w.handle];
    end else if (pick < 88) begin
      w.func = FUNC_RELEASE;
      w.handle = held_slot();
    end else if (pick < 92) begin
      w.func = FUNC_UNDEFINED;
    end
    // The remaining words acquire a key outside the pool.
    return w;
  endfunction

  // Waits until every word has been taken and answered, then lets the
  // block settle.
  task automatic drain();
    while (pending_words.size() != 0 || req_valid || answers_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // The lifetime register is written only while the block is idle.
  task automatic write_lifetime(input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    lease_len = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence: a directed part at the reset lifetime, then random phases,
  // each under its own lifetime setting.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0] life_set [RANDOM_PHASES];
    int          step_set [RANDOM_PHASES];

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Bad handles on an empty table and the undefined function code.
    pending_words.push_back(make_word(FUNC_RELEASE, 8'd0, '0, 4'd5, 32'd0));
    pending_words.push_back(make_word(FUNC_RENEW, 8'd0, '0, 4'd0, 32'd0));
    pending_words.push_back(make_word(FUNC_UNDEFINED, '1, '1, '1, '1));
    // Grant, then a refusal exactly at the expiry time.
    pending_words.push_back(make_word(FUNC_ACQUIRE, 8'd0, '0, 4'd0, 32'd100));
    pending_words.push_back(make_word(FUNC_ACQUIRE, 8'd0, '0, 4'd0, 32'd400));
    // Extreme keys, and a key that differs only in its filesystem.
    pending_words.push_back(make_word(FUNC_ACQUIRE, 8'd255, '1, 4'd0, 32'd0));
    pending_words.push_back(make_word(FUNC_ACQUIRE, 8'd0, '1, 4'd0, 32'd50));
    // Renew ok, renew from another filesystem, renew after expiry.
    pending_words.push_back(make_word(FUNC_RENEW, 8'd0, '0, 4'd0, 32'd400));
    pending_words.push_back(make_word(FUNC_RENEW, 8'd7, '0, 4'd1, 32'd10));
    pending_words.push_back(make_word(FUNC_RENEW, 8'd0, '0, 4'd0, 32'd701));
    // Re-acquire over the expired lease marks it dead; a renew through the
    // old handle is then broken even at a time before its expiry.
    pending_words.push_back(make_word(FUNC_ACQUIRE, 8'd0, '0, 4'd0, 32'd701));
    pending_words.push_back(make_word(FUNC_RENEW, 8'd0, '0, 4'd0, 32'd0));
    // Release, double release, release of the top unused handle.
    pending_words.push_back(make_word(FUNC_RELEASE, 8'd0, '0, 4'd0, 32'd0));
    pending_words.push_back(make_word(FUNC_RELEASE, 8'd0, '0, 4'd0, 32'd0));
    pending_words.push_back(make_word(FUNC_RELEASE, 8'd0, '0, 4'd15, 32'd0));
    // Expiry that wraps past 2^32, then a renew after the wrap.
    pending_words.push_back(make_word(FUNC_ACQUIRE, 8'hA5, 64'h5A5A_A5A5_0FF0_F00F,
                                      4'd0, 32'hFFFF_FF00));
    pending_words.push_back(make_word(FUNC_RENEW, 8'hA5, '0, 4'd0, 32'h0000_0020));
    pending_words.push_back(make_word(FUNC_RELEASE, 8'd0, '0, 4'd3, 32'd0));
    drain();

    // Lifetime settings with the extremes; the time step is sized so that
    // leases both survive and expire within a phase.
    life_set[0] = 32'd0;                        step_set[0] = 2;
    life_set[1] = 32'hFFFF_FFFF;                step_set[1] = 3;
    life_set[2] = LEASE_DEFAULT;                step_set[2] = 20;
    life_set[3] = $urandom_range(20, 400);      step_set[3] = 8;
    life_set[4] = 32'd1;                        step_set[4] = 2;
    life_set[5] = $urandom;                     step_set[5] = 40;

    key_fs[0] = 8'd0;
    key_fs[1] = 8'd255;
    key_path[0] = '0;
    key_path[1] = '1;

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_lifetime(life_set[ph]);
      key_fs[2] = 8'($urandom);
      key_fs[3] = 8'($urandom);
      for (int p = 2; p < 5; p++) key_path[p] = {$urandom, $urandom};
      // One phase runs the clock across the 2^32 wrap.
      if (ph == 2) gen_now = 32'hFFFF_FF00;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // Keep the queue short so that handle picks follow the table closely.
        while (pending_words.size() >= 4) @(negedge clk);
        pending_words.push_back(next_word(step_set[ph]));
      end
      drain();
    end

    if (answers_due.size() != 0)
      log_mismatch($sformatf("%0d responses never arrived", answers_due.size()));
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
